@@ rtl/core/drp_pkg.sv @@
// Shared constants and types for the disparity reprojection pipeline.
package drp_pkg;

  localparam int ENTRY_W    = 32;        // one signed Q12.20 matrix entry
  localparam int CFG_W      = 64;        // two entries per register
  localparam int CFG_IDX_W  = 3;
  localparam int Q_WORDS    = 8;
  localparam int DISP_W     = 16;
  localparam int FRAC_BITS  = 16;        // Q15.16 output
  localparam int QUO_W      = 31;        // quotient bits below saturation
  localparam int DIV_LAT    = QUO_W + 1; // prep stage plus one stage per bit
  localparam int GRAY_W     = 8;
  localparam int Z_OUT_W    = 23;

  localparam logic signed [31:0] Z_LOW     = 32'sd131072;   // 2 m
  localparam logic signed [31:0] Z_HIGH    = 32'sd5242880;  // 80 m
  localparam logic [31:0]        MISSING_Z = 32'd655360;    // 10 m
  localparam logic [31:0]        SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_NEG   = 32'h8000_0000;

  // Register indexes of the matrix words.
  localparam logic [CFG_IDX_W-1:0] Q_R0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] Q_R0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] Q_R1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] Q_R1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] Q_R2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] Q_R2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] Q_R3_C01 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] Q_R3_C23 = 3'd7;

  // Per-item side information that rides along the divider pipeline.
  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              missing;
    logic              wzero;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
  } side_t;

endpackage

@@ rtl/core/drp_div.sv @@
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
module drp_div #(
  parameter int MAG_W = 59
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [MAG_W-1:0]           num,
  input  logic [MAG_W+9:0]           den,
  output logic [drp_pkg::QUO_W-1:0]  quo,
  output logic                       sat
);
  import drp_pkg::*;

  localparam int D_W   = MAG_W + 10;
  localparam int REM_W = D_W + 1;
  localparam int SH    = QUO_W - FRAC_BITS;

  logic [REM_W-1:0] rem  [0:QUO_W];
  logic [D_W-1:0]   dd   [0:QUO_W];
  logic [QUO_W-1:0] feed [0:QUO_W];
  logic [QUO_W-1:0] qq   [0:QUO_W];
  logic             st   [0:QUO_W];

  // Prep: flag quotients of 2^31 or more, seed the remainder with the top bits.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]   <= (SH + D_W)'(num) >= {den, SH'(0)};
      rem[0]  <= REM_W'(num >> SH);
      feed[0] <= {num[SH-1:0], FRAC_BITS'(0)};
      dd[0]   <= den;
      qq[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = {rem[k-1][REM_W-2:0], feed[k-1][QUO_W-1]};
    assign ge    = trial >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? trial - {1'b0, dd[k-1]} : trial;
        qq[k]   <= {qq[k-1][QUO_W-2:0], ge};
        feed[k] <= {feed[k-1][QUO_W-2:0], 1'b0};
        dd[k]   <= dd[k-1];
        st[k]   <= st[k-1];
      end
    end
  end

  assign quo = qq[QUO_W];
  assign sat = st[QUO_W];

endmodule

@@ rtl/core/disparity_reproject_to_points.sv @@
// Top level: reprojects one disparity pixel per clock, unless the output stalls, to a metric 3-D point.
//
// Each accepted pixel (col, row, disparity, gray, missing) is multiplied by
// the 4x4 matrix held in eight 64-bit registers, giving X, Y, Z and W.
// X, Y and Z are then divided by 1000*W in three parallel bit-per-stage
// divider pipelines and saturated into signed Q15.16 metres. A pixel flagged
// missing gets z = 10 m. A point leaves only when W is nonzero and
// 2 m <= z <= 80 m; otherwise the transaction produces no output. One pixel
// is taken per clock while the pipeline advances; from accept to output it
// passes three arithmetic stages, the 32-stage divider and one output
// register. The whole pipeline holds while a result waits and out_ready is
// low; while no result waits it advances every cycle. Write the matrix only
// while the pipeline is idle.
module disparity_reproject_to_points #(
  parameter int COORD_BITS     = 12,
  parameter int DISP_FRAC_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [drp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [drp_pkg::CFG_W-1:0]     wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [11:0]                   pixel_col,
  input  logic [11:0]                   pixel_row,
  input  logic [15:0]                   disparity,
  input  logic [7:0]                    gray,
  input  logic                          missing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            x_m,
  output logic signed [31:0]            y_m,
  output logic [22:0]                   z_m,
  output logic [23:0]                   rgb
);
  import drp_pkg::*;

  // Column/row bits actually used, and the width of the exact row sums.
  localparam int CB        = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int F         = DISP_FRAC_BITS;
  localparam int TERM_BITS = (CB + F > DISP_W) ? CB + F : DISP_W;
  localparam int SUM_W     = ENTRY_W + TERM_BITS + 2;
  localparam int MAG_W     = SUM_W;
  localparam int D_W       = MAG_W + 10;
  localparam int PC_W      = ENTRY_W + CB + 1;
  localparam int PD_W      = ENTRY_W + DISP_W + 1;

  // Matrix registers.
  logic [CFG_W-1:0] q_cfg [0:Q_WORDS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_WORDS; i++) q_cfg[i] <= '0;
    end else if (wr_en) begin
      q_cfg[wr_index] <= wr_data;
    end
  end

  // Entry (r,c): even column in the low word, odd column in the high word.
  logic signed [ENTRY_W-1:0] qe [0:3][0:3];
  for (genvar r = 0; r < 4; r++) begin : g_ent
    assign qe[r][0] = $signed(q_cfg[2*r][ENTRY_W-1:0]);
    assign qe[r][1] = $signed(q_cfg[2*r][CFG_W-1:ENTRY_W]);
    assign qe[r][2] = $signed(q_cfg[2*r+1][ENTRY_W-1:0]);
    assign qe[r][3] = $signed(q_cfg[2*r+1][CFG_W-1:ENTRY_W]);
  end

  // Global advance: hold everything while a result is stalled at the output.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: matrix products.
  logic                   a_valid;
  logic signed [PC_W-1:0] a_pc [0:3];
  logic signed [PC_W-1:0] a_pr [0:3];
  logic signed [PD_W-1:0] a_pd [0:3];
  logic [GRAY_W-1:0]      a_gray;
  logic                   a_missing;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        a_pc[r] <= qe[r][0] * $signed({1'b0, pixel_col[CB-1:0]});
        a_pr[r] <= qe[r][1] * $signed({1'b0, pixel_row[CB-1:0]});
        a_pd[r] <= qe[r][2] * $signed({1'b0, disparity});
      end
      a_gray    <= gray;
      a_missing <= missing;
    end
  end

  // Stage B: exact row sums with 20+F fraction bits.
  logic                    b_valid;
  logic signed [SUM_W-1:0] b_sum [0:3];
  logic [GRAY_W-1:0]       b_gray;
  logic                    b_missing;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        b_sum[r] <= (SUM_W'(a_pc[r]) <<< F) + (SUM_W'(a_pr[r]) <<< F)
                  + SUM_W'(a_pd[r]) + (SUM_W'(qe[r][3]) <<< F);
      end
      b_gray    <= a_gray;
      b_missing <= a_missing;
    end
  end

  // Stage C: magnitudes, quotient signs, divisor scaled by 1000.
  logic             c_valid;
  logic [MAG_W-1:0] c_un [0:2];
  logic [D_W-1:0]   c_den;
  side_t            c_side;

  logic [MAG_W-1:0] mag_b [0:3];
  logic [D_W-1:0]   uw_ext;
  for (genvar r = 0; r < 4; r++) begin : g_abs
    assign mag_b[r] = b_sum[r][SUM_W-1] ? MAG_W'(-b_sum[r]) : MAG_W'(b_sum[r]);
  end
  assign uw_ext = D_W'(mag_b[3]);

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) c_un[r] <= mag_b[r];
      c_den          <= (uw_ext << 10) - (uw_ext << 4) - (uw_ext << 3);
      c_side.gray    <= b_gray;
      c_side.missing <= b_missing;
      c_side.wzero   <= (b_sum[3] == '0);
      c_side.neg_x   <= b_sum[0][SUM_W-1] ^ b_sum[3][SUM_W-1];
      c_side.neg_y   <= b_sum[1][SUM_W-1] ^ b_sum[3][SUM_W-1];
      c_side.neg_z   <= b_sum[2][SUM_W-1] ^ b_sum[3][SUM_W-1];
    end
  end

  // Dividers for X, Y and Z.
  logic [QUO_W-1:0] quo [0:2];
  logic             sat [0:2];
  for (genvar r = 0; r < 3; r++) begin : g_div
    drp_div #(.MAG_W(MAG_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (c_un[r]),
      .den (c_den),
      .quo (quo[r]),
      .sat (sat[r])
    );
  end

  // Side information and valid bits, aligned with the divider latency.
  logic  sb_valid [0:DIV_LAT-1];
  side_t sb       [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) sb_valid[k] <= 1'b0;
    end else if (en) begin
      sb_valid[0] <= c_valid;
      for (int k = 1; k < DIV_LAT; k++) sb_valid[k] <= sb_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= c_side;
      for (int k = 1; k < DIV_LAT; k++) sb[k] <= sb[k-1];
    end
  end

  // Output stage: apply sign and saturation, check the depth window.
  side_t       d_side;
  logic [31:0] coord [0:2];
  logic [31:0] z_val;
  logic        keep;

  assign d_side = sb[DIV_LAT-1];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic neg;
      neg = (r == 0) ? d_side.neg_x : (r == 1) ? d_side.neg_y : d_side.neg_z;
      if (sat[r]) coord[r] = neg ? SAT_NEG : SAT_POS;
      else if (neg) coord[r] = -{1'b0, quo[r]};
      else coord[r] = {1'b0, quo[r]};
    end
    z_val = d_side.missing ? MISSING_Z : coord[2];
    keep  = !d_side.wzero && ($signed(z_val) >= Z_LOW) && ($signed(z_val) <= Z_HIGH);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= sb_valid[DIV_LAT-1] && keep;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_m <= $signed(coord[0]);
      y_m <= $signed(coord[1]);
      z_m <= z_val[Z_OUT_W-1:0];
      rgb <= {d_side.gray, d_side.gray, d_side.gray};
    end
  end

  // Every emitted point lies inside the depth window.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (z_m >= Z_LOW[Z_OUT_W-1:0]) && (z_m <= Z_HIGH[Z_OUT_W-1:0]))
    else $error("point emitted outside depth window");

  // Color bytes always agree.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rgb[23:16] == rgb[7:0]) && (rgb[15:8] == rgb[7:0]))
    else $error("rgb bytes differ");

  // Nothing comes out right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

@@ tb/sv/drp_point_checker.sv @@
// Checker: predicts reprojected points from accepted pixels and compares outputs.
module drp_point_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [2:0]                wr_index,
  input  logic [63:0]               wr_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [11:0]               pixel_col,
  input  logic [11:0]               pixel_row,
  input  logic [15:0]               disparity,
  input  logic [7:0]                gray,
  input  logic                      missing,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [31:0]        x_m,
  input  logic signed [31:0]        y_m,
  input  logic [22:0]               z_m,
  input  logic [23:0]               rgb,
  output int                        error_count,
  output int                        pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [22:0]        z;
    logic [23:0]        rgb;
  } point_t;

  logic [63:0] q_words [8];
  point_t      point_queue [$];

  assign pending_points = point_queue.size();

  function automatic logic signed [63:0] q_entry(int r, int c);
    logic [63:0] w;
    w = q_words[r * 2 + c / 2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  function automatic logic signed [63:0] row_acc(int r, longint cl, longint rw, longint dp);
    return q_entry(r, 0) * cl * 16 + q_entry(r, 1) * rw * 16
         + q_entry(r, 2) * dp + q_entry(r, 3) * 16;
  endfunction

  // Truncating quotient into Q15.16 metres, then saturate.
  function automatic logic signed [63:0] metres(logic signed [63:0] n, logic signed [63:0] d);
    logic [63:0] un, ud, ip, rem, frac, mag;
    logic        neg;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    neg = (n < 0) != (d < 0);
    frac = 0;
    ip = un / ud;
    rem = un % ud;
    if (ip >= (64'd1 << 40)) begin
      mag = 64'd1 << 40;
    end else begin
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          frac[0] = 1'b1;
        end
      end
      mag = ((ip << 16) | frac) / 1000;
    end
    if (neg) return mag >= 64'h8000_0000 ? -64'sh8000_0000 : -$signed(mag);
    return mag > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : $signed(mag);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    logic signed [63:0] xs, ys, zs, ws, z;
    point_t p, e;
    if (rst) begin
      foreach (q_words[i]) q_words[i] <= '0;
      error_count = 0;
    end else begin
      if (wr_en) q_words[wr_index] <= wr_data;
      if (in_valid && in_ready) begin
        xs = row_acc(0, pixel_col, pixel_row, disparity);
        ys = row_acc(1, pixel_col, pixel_row, disparity);
        zs = row_acc(2, pixel_col, pixel_row, disparity);
        ws = row_acc(3, pixel_col, pixel_row, disparity);
        if (ws != 0) begin
          z = missing ? 64'sd655360 : metres(zs, ws);
          if (z >= 131072 && z <= 5242880) begin
            p.x = metres(xs, ws);
            p.y = metres(ys, ws);
            p.z = z[22:0];
            p.rgb = {gray, gray, gray};
            point_queue.insert(point_queue.size(), p);
          end
        end
      end
      if (out_valid && out_ready) begin
        if (point_queue.size() == 0) begin
          report("unexpected point", {x_m, y_m}, '0);
        end else begin
          e = point_queue.pop_front();
          if (x_m !== e.x) report("x_m", x_m, e.x);
          if (y_m !== e.y) report("y_m", y_m, e.y);
          if (z_m !== e.z) report("z_m", z_m, e.z);
          if (rgb !== e.rgb) report("rgb", rgb, e.rgb);
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_disparity_reproject_to_points.sv @@
// Testbench top: drives pixels and matrix writes, stalls both sides, gives the verdict.
module tb_disparity_reproject_to_points;
  timeunit 1ns;
  timeprecision 1ps;
  import drp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  // Q12.20 constants
  localparam logic [31:0] ONE   = 32'h0010_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [63:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] pixel_col = '0;
  logic [11:0] pixel_row = '0;
  logic [15:0] disparity = '0;
  logic [7:0]  gray = '0;
  logic        missing = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] x_m, y_m;
  logic [22:0] z_m;
  logic [23:0] rgb;
  int          error_count, pending_points;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  disparity_reproject_to_points dut (.*);
  drp_point_checker checker_i (.*);

  // Randomly stall the result side.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write one matrix register; pipeline must be idle. The caller drops wr_en.
  task automatic write_q(logic [2:0] idx, logic [63:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  // Drop the input, wait until every expected point has come out, then let
  // empty slots drain.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load a full matrix given as 16 entries, row by row.
  task automatic load_matrix(logic [31:0] m [16]);
    drain();
    for (int r = 0; r < 4; r++) begin
      write_q(3'(r * 2), {m[r * 4 + 1], m[r * 4]});
      write_q(3'(r * 2 + 1), {m[r * 4 + 3], m[r * 4 + 2]});
    end
    wr_en <= 1'b0;
  endtask

  // Offer one pixel and hold it until the transaction completes.
  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [15:0] d,
                            logic [7:0] g, logic ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_col <= c;
    pixel_row <= r;
    disparity <= d;
    gray <= g;
    missing <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Plausible stereo matrix: X=c-cx, Y=r-cy, Z=f, W=d/B, scaled to mm.
  task automatic stereo_matrix(output logic [31:0] m [16]);
    int f, cx, cy;
    f  = $urandom_range(200, 1500);
    cx = $urandom_range(0, 2000);
    cy = $urandom_range(0, 2000);
    foreach (m[i]) m[i] = '0;
    m[0]  = ONE;
    m[3]  = -(cx * ONE);
    m[5]  = ONE;
    m[7]  = -(cy * ONE);
    m[11] = f * ONE;
    // 1/B with B ~ 0.05..0.5 m expressed in mm: W = d / Bmm
    m[14] = $urandom_range(2000, 20000);
    m[15] = $urandom_range(0, 3) == 0 ? $urandom() : 32'h0;
  endtask

  // Random pixel that mostly lands in the depth window for stereo matrices.
  task automatic random_pixel(bit anything);
    logic [15:0] d;
    d = anything ? 16'($urandom()) : 16'($urandom_range(16, 4000));
    send_pixel(12'($urandom()), 12'($urandom()), d, 8'($urandom()),
               $urandom_range(9) == 0);
  endtask

  initial begin
    logic [31:0] m [16];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All-zero matrix after reset: W is zero, nothing comes out, even if missing.
    send_pixel(12'h0, 12'h0, 16'h0, 8'h00, 1'b1);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 1'b0);

    // Directed: Z=W*const giving exact depths, X/Y pushing saturation.
    foreach (m[i]) m[i] = '0;
    m[0] = 32'h7FFF_FFFF;           // huge positive X
    m[5] = 32'h8000_0000;           // huge negative Y
    m[11] = 32'd1000 * 32'd80;      // Z constant
    m[15] = 32'd1;                  // W constant -> z = 80 m exactly
    load_matrix(m);
    send_pixel(12'hFFF, 12'hFFF, 16'h0, 8'hA5, 1'b0);
    send_pixel(12'h000, 12'h000, 16'hFFFF, 8'h5A, 1'b0);
    send_pixel(12'h001, 12'h800, 16'h8000, 8'h01, 1'b1);
    m[11] = 32'd1000 * 32'd80 + 32'd1;   // a hair above 80 m, just outside the window
    m[15] = 32'd1;
    load_matrix(m);
    send_pixel(12'h7FF, 12'h123, 16'h0010, 8'h80, 1'b0);
    m[11] = 32'd2000; m[15] = 32'd1;      // 2 m exactly
    load_matrix(m);
    send_pixel(12'h0AA, 12'h555, 16'h00FF, 8'h7F, 1'b0);
    m[11] = 32'd1999;                      // just below 2 m
    load_matrix(m);
    send_pixel(12'h555, 12'hAAA, 16'h0F0F, 8'hFE, 1'b0);
    send_pixel(12'h555, 12'hAAA, 16'h0F0F, 8'hFE, 1'b1);   // missing rescues it
    m[11] = 32'hFFFF_F000;                 // negative depth
    load_matrix(m);
    send_pixel(12'h321, 12'h654, 16'h1234, 8'h33, 1'b0);
    m[11] = 32'd50000; m[15] = 32'hFFFF_FFFF;   // negative W, negative N
    m[3] = 32'h8000_0000; m[7] = 32'h7FFF_FFFF;
    load_matrix(m);
    send_pixel(12'h010, 12'h020, 16'h0040, 8'h44, 1'b0);
    send_pixel(12'hFFF, 12'h000, 16'hFFFF, 8'hC3, 1'b1);

    // Random phases: stereo-like matrices with random pixels, plus noise matrices.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 24 : phase == 1 ? 86 : 0;
      recv_idle_pct = phase == 0 ? 86 : phase == 1 ? 24 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        if (blk == 5) begin
          foreach (m[i]) m[i] = $urandom();
        end else begin
          stereo_matrix(m);
        end
        load_matrix(m);
        for (int k = 0; k < 60; k++) random_pixel(blk == 5 || k % 8 == 0);
        // Hold the sender until every expected point has arrived.
        if (blk == 2) drain();
      end
    end

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ disparity_reproject_to_points.f @@
rtl/core/drp_pkg.sv
rtl/core/drp_div.sv
rtl/core/disparity_reproject_to_points.sv
tb/sv/drp_point_checker.sv
tb/sv/tb_disparity_reproject_to_points.sv
